// ----- sv/hdtf_pkg.sv -----
// shared types, constants and crc helper for the humidity and temperature frame decoder
`default_nettype none

package hdtf_pkg;

  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam int unsigned FrameLen   = 6;
  localparam int unsigned TempScale  = 17500;
  localparam int unsigned TempOffset = 4500;
  localparam int unsigned HumidScale = 10000;
  localparam int unsigned FullScale  = 65535;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TEMP_BAD  = 2'd1,
    STATUS_HUMID_BAD = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        humid_centi;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_humid;
    logic        temp_ok;
    logic        humid_ok;
  } frame_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hdtf_front.sv -----
// front end: frame position, running crc and raw word capture
`default_nettype none

module hdtf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  hdtf_pkg::in_t   in_i,
  output logic            push_o,
  output hdtf_pkg::frame_t frame_o
);
  import hdtf_pkg::*;

  localparam logic [2:0] PosTempMsb  = 3'd0;
  localparam logic [2:0] PosTempLsb  = 3'd1;
  localparam logic [2:0] PosTempCrc  = 3'd2;
  localparam logic [2:0] PosHumidMsb = 3'd3;
  localparam logic [2:0] PosHumidLsb = 3'd4;
  localparam logic [2:0] PosHumidCrc = 3'd5;

  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  crc_q, crc_d;
  logic        temp_ok_q, temp_ok_d;
  logic [15:0] raw_temp_q, raw_temp_d;
  logic [15:0] raw_humid_q, raw_humid_d;
  logic [2:0]  pos;
  logic [7:0]  b;

  assign b   = in_i.data_byte;
  assign pos = (in_i.frame_start || (byte_pos_q > 3'(FrameLen - 1))) ? PosTempMsb : byte_pos_q;

  always_comb begin
    byte_pos_d  = byte_pos_q;
    crc_d       = crc_q;
    temp_ok_d   = temp_ok_q;
    raw_temp_d  = raw_temp_q;
    raw_humid_d = raw_humid_q;
    push_o      = 1'b0;
    if (accept_i) begin
      byte_pos_d = pos + 3'd1;
      case (pos)
        PosTempMsb: begin
          raw_temp_d[15:8] = b;
          crc_d            = crc8_update(CrcInit, b);
          temp_ok_d        = 1'b0;
        end
        PosTempLsb: begin
          raw_temp_d[7:0] = b;
          crc_d           = crc8_update(crc_q, b);
        end
        PosTempCrc: begin
          temp_ok_d = (b == crc_q);
          crc_d     = CrcInit;
        end
        PosHumidMsb: begin
          raw_humid_d[15:8] = b;
          crc_d             = crc8_update(CrcInit, b);
        end
        PosHumidLsb: begin
          raw_humid_d[7:0] = b;
          crc_d            = crc8_update(crc_q, b);
        end
        PosHumidCrc: begin
          push_o     = 1'b1;
          crc_d      = CrcInit;
          byte_pos_d = PosTempMsb;
        end
        default: begin
          byte_pos_d = PosTempMsb;
        end
      endcase
    end
  end

  assign frame_o.raw_temp  = raw_temp_q;
  assign frame_o.raw_humid = raw_humid_q;
  assign frame_o.temp_ok   = temp_ok_q;
  assign frame_o.humid_ok  = (b == crc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= PosTempMsb;
      crc_q      <= CrcInit;
      temp_ok_q  <= 1'b0;
    end else begin
      byte_pos_q <= byte_pos_d;
      crc_q      <= crc_d;
      temp_ok_q  <= temp_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_temp_q  <= raw_temp_d;
    raw_humid_q <= raw_humid_d;
  end

endmodule

`default_nettype wire

// ----- sv/hdtf_fifo.sv -----
// short frame queue between the byte front end and the conversion back end
`default_nettype none

module hdtf_fifo #(
  parameter int unsigned Depth = hdtf_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hdtf_pkg::frame_t frame_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output hdtf_pkg::frame_t frame_o
);
  import hdtf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign frame_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/hdtf_back.sv -----
// back end: scaling multiply, divide by full scale and output register
`default_nettype none

module hdtf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_valid_i,
  input  hdtf_pkg::frame_t frame_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hdtf_pkg::out_t   out_o
);
  import hdtf_pkg::*;

  localparam logic [30:0] TempMul  = 31'(TempScale);
  localparam logic [29:0] HumidMul = 30'(HumidScale);
  localparam logic [16:0] FullCmp  = 17'(FullScale);

  logic        s1_valid_q;
  logic [30:0] t_prod_q;
  logic [29:0] h_prod_q;
  status_e     status_q;
  logic        out_valid_q;
  out_t        out_q;

  logic        advance, s1_ready;
  logic [14:0] t_q0, t_val;
  logic [13:0] h_q0, h_val;
  logic [16:0] t_rem, h_rem;
  status_e     status_d;

  assign advance  = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || advance;
  assign pop_o    = frame_valid_i && s1_ready;

  always_comb begin
    if (!frame_i.temp_ok) begin
      status_d = STATUS_TEMP_BAD;
    end else if (!frame_i.humid_ok) begin
      status_d = STATUS_HUMID_BAD;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // x / 65535 as (x >> 16) plus one correction step
  assign t_q0  = t_prod_q[30:16];
  assign t_rem = 17'(t_prod_q[15:0]) + 17'(t_q0);
  assign t_val = t_q0 + 15'(t_rem >= FullCmp);
  assign h_q0  = h_prod_q[29:16];
  assign h_rem = 17'(h_prod_q[15:0]) + 17'(h_q0);
  assign h_val = h_q0 + 14'(h_rem >= FullCmp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= frame_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      t_prod_q <= 31'(frame_i.raw_temp) * TempMul;
      h_prod_q <= 30'(frame_i.raw_humid) * HumidMul;
      status_q <= status_d;
    end
    if (advance && s1_valid_q) begin
      out_q.temp_centi  <= $signed(t_val - 15'(TempOffset));
      out_q.humid_centi <= h_val;
      out_q.status      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ----- sv/humidity_temp_frame_decoder_top.sv -----
// top level of the humidity and temperature measurement frame decoder
`default_nettype none

// Takes one frame byte per cycle while not stalled (temperature word, its crc-8, humidity
// word, its crc-8; crc polynomial 0x31, start 0xff per word) and gives one result per
// six-byte frame, in hundredths of a degree and of a percent.
// A byte is taken every cycle; input stall rises only when QueueDepth finished frames wait
// in the queue in front of the conversion pipeline, i.e. when the result side stalls.
// frame_start forces the byte to be the first of a new frame.
module humidity_temp_frame_decoder_top #(
  parameter int unsigned QueueDepth = hdtf_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hdtf_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hdtf_pkg::out_t out_o
);
  import hdtf_pkg::*;

  logic   in_accept;
  logic   push, fifo_full, fifo_valid, pop;
  frame_t front_frame, queue_frame;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = fifo_full;

  hdtf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .in_i     (in_i),
    .push_o   (push),
    .frame_o  (front_frame)
  );

  hdtf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (front_frame),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .frame_o (queue_frame)
  );

  hdtf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (fifo_valid),
    .frame_i       (queue_frame),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_o         (out_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full) else $error("frame pushed into full queue");

  a_humid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.humid_centi <= 14'(HumidScale)))
    else $error("humidity out of range");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.temp_centi >= -15'sd4500 && out_o.temp_centi <= 15'sd13000))
    else $error("temperature out of range");

endmodule

`default_nettype wire
